/* rtl/core/dat_pkg.sv */
// Shared types and constants of the arrival-time delay block.
// Holds the request/result structs, the CORDIC arctan table and the site table.
package dat_pkg;

  localparam int ANGLE_BITS = 24;
  localparam int DELAY_BITS = 26;
  localparam int NUM_SITES  = 6;
  localparam int DET_BITS   = 3;
  localparam int CW         = 33;   // CORDIC x/y width
  localparam int ZW         = 32;   // CORDIC residual angle width
  localparam int UW         = 32;   // site light-time width, 2^-4 ns

  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sh026DD3B6A;

  typedef struct packed {
    logic [DET_BITS-1:0]          detector;
    logic [ANGLE_BITS-1:0]        right_ascension;
    logic signed [ANGLE_BITS-1:0] declination;
  } req_t;

  typedef struct packed {
    logic signed [DELAY_BITS-1:0] delay_ns;
    logic                         status;
  } res_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_UNKNOWN = 1'b1
  } status_t;

  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Site positions in mm turned into light travel time, 2^-4 ns, ties away from zero.
  localparam longint LIGHT_MPS = 299792458;
  localparam longint HALF_L    = LIGHT_MPS / 2;
  localparam longint SCALE     = 16000000;

  localparam longint U00 =  ((64'sd2161414928 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U01 = -((64'sd3834695183 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U02 =  ((64'sd4600350224 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U10 = -((64'sd74276042   * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U11 = -((64'sd5496283721 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U12 =  ((64'sd3224257016 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U20 =  ((64'sd4546374100 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U21 =  ((64'sd842989700  * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U22 =  ((64'sd4378577000 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U30 =  ((64'sd3856311200 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U31 =  ((64'sd666597800  * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U32 =  ((64'sd5019640600 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U40 = -((64'sd3776899062 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U41 =  ((64'sd3483900163 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U42 =  ((64'sd3766657585 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U50 = -((64'sd3946409000 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U51 =  ((64'sd3366259000 * SCALE + HALF_L) / LIGHT_MPS);
  localparam longint U52 =  ((64'sd3699150700 * SCALE + HALF_L) / LIGHT_MPS);

  localparam logic signed [UW-1:0] SITE_X [NUM_SITES] = '{
    UW'(U00), UW'(U10), UW'(U20), UW'(U30), UW'(U40), UW'(U50)};
  localparam logic signed [UW-1:0] SITE_Y [NUM_SITES] = '{
    UW'(U01), UW'(U11), UW'(U21), UW'(U31), UW'(U41), UW'(U51)};
  localparam logic signed [UW-1:0] SITE_Z [NUM_SITES] = '{
    UW'(U02), UW'(U12), UW'(U22), UW'(U32), UW'(U42), UW'(U52)};

endpackage

/* rtl/core/dat_cordic_stage.sv */
// One registered CORDIC rotation stage with a fixed shift.
// Depends on dat_pkg for widths and the arctan table.
module dat_cordic_stage #(
  parameter int K = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [dat_pkg::CW-1:0] x_in,
  input  logic signed [dat_pkg::CW-1:0] y_in,
  input  logic signed [dat_pkg::ZW-1:0] z_in,
  input  logic [1:0]                    q_in,
  output logic signed [dat_pkg::CW-1:0] x,
  output logic signed [dat_pkg::CW-1:0] y,
  output logic signed [dat_pkg::ZW-1:0] z,
  output logic [1:0]                    q
);

  localparam logic signed [dat_pkg::ZW-1:0] ATAN = dat_pkg::ATAN_TURN[K];

  logic signed [dat_pkg::CW-1:0] dx, dy;

  assign dx = y_in >>> K;
  assign dy = x_in >>> K;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_in;
      if (!z_in[dat_pkg::ZW-1]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
    end
  end

endmodule

/* rtl/core/dat_trig.sv */
// Pipelined cosine/sine unit: quadrant split, CORDIC stages, quadrant fold.
// Depends on dat_pkg and dat_cordic_stage.
module dat_trig #(
  parameter int TRIG_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [31:0]                   ang,
  output logic signed [dat_pkg::CW-1:0] c,
  output logic signed [dat_pkg::CW-1:0] s
);

  logic [31:0] t;
  logic signed [dat_pkg::CW-1:0] xs [TRIG_STAGES+1];
  logic signed [dat_pkg::CW-1:0] ys [TRIG_STAGES+1];
  logic signed [dat_pkg::ZW-1:0] zs [TRIG_STAGES+1];
  logic [1:0]                    qs [TRIG_STAGES+1];
  logic signed [dat_pkg::CW-1:0] xf, yf;

  assign t = ang + 32'h20000000;

  // Split into nearest quadrant and residual in [-1/8, 1/8) turn.
  always_ff @(posedge clk) begin
    if (en) begin
      qs[0] <= t[31:30];
      zs[0] <= $signed({2'b00, t[29:0]}) - 32'sh20000000;
      xs[0] <= dat_pkg::CORDIC_GAIN;
      ys[0] <= '0;
    end
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    dat_cordic_stage #(.K(i)) u_stage (
      .clk (clk),
      .en  (en),
      .x_in(xs[i]),
      .y_in(ys[i]),
      .z_in(zs[i]),
      .q_in(qs[i]),
      .x   (xs[i+1]),
      .y   (ys[i+1]),
      .z   (zs[i+1]),
      .q   (qs[i+1])
    );
  end

  assign xf = xs[TRIG_STAGES];
  assign yf = ys[TRIG_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      case (qs[TRIG_STAGES])
        2'd0: begin c <= xf;  s <= yf;  end
        2'd1: begin c <= -yf; s <= xf;  end
        2'd2: begin c <= -xf; s <= -yf; end
        default: begin c <= yf; s <= -xf; end
      endcase
    end
  end

  // zs of the last stage only steers nothing further
  logic unused_z;
  assign unused_z = ^zs[TRIG_STAGES];

endmodule

/* rtl/core/dat_dot.sv */
// Direction products, site dot product and rounding to nanoseconds.
// Depends on dat_pkg.
module dat_dot (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [dat_pkg::CW-1:0]     cr,
  input  logic signed [dat_pkg::CW-1:0]     sr,
  input  logic signed [dat_pkg::CW-1:0]     cd,
  input  logic signed [dat_pkg::CW-1:0]     sd,
  input  logic [dat_pkg::DET_BITS-1:0]      det,
  output dat_pkg::res_t                     res
);

  localparam int PW = 2 * dat_pkg::CW;
  localparam int QW = dat_pkg::UW + dat_pkg::CW;
  localparam int SW = QW + 2;

  logic [dat_pkg::DET_BITS-1:0] det1, det2, det3, det4;
  logic signed [PW-1:0] pc, ps, pc_r, ps_r;
  logic signed [dat_pkg::CW-1:0] sd1, sd2, ux, uy;
  logic signed [QW-1:0] px, py, pz;
  logic signed [SW-1:0] sxy, sz3, total;
  logic [2:0] idx;

  assign idx = (det2 < 3'(dat_pkg::NUM_SITES)) ? det2 : 3'd0;

  // M1: horizontal products
  always_ff @(posedge clk) begin
    if (en) begin
      pc   <= PW'(cd) * PW'(cr);
      ps   <= PW'(cd) * PW'(sr);
      sd1  <= sd;
      det1 <= det;
    end
  end

  assign pc_r = pc + PW'(64'sd536870912);
  assign ps_r = ps + PW'(64'sd536870912);

  // M2: round back to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      ux   <= dat_pkg::CW'(pc_r >>> 30);
      uy   <= dat_pkg::CW'(ps_r >>> 30);
      sd2  <= sd1;
      det2 <= det1;
    end
  end

  // M3: site products
  always_ff @(posedge clk) begin
    if (en) begin
      px   <= QW'(dat_pkg::SITE_X[idx]) * QW'(ux);
      py   <= QW'(dat_pkg::SITE_Y[idx]) * QW'(uy);
      pz   <= QW'(dat_pkg::SITE_Z[idx]) * QW'(sd2);
      det3 <= det2;
    end
  end

  // M4: partial sum
  always_ff @(posedge clk) begin
    if (en) begin
      sxy  <= SW'(px) + SW'(py);
      sz3  <= SW'(pz) + SW'(64'sd8589934592);
      det4 <= det3;
    end
  end

  assign total = sxy + sz3;

  // M5: final sum, round to ns
  always_ff @(posedge clk) begin
    if (en) begin
      if (det4 < 3'(dat_pkg::NUM_SITES)) begin
        res.delay_ns <= dat_pkg::DELAY_BITS'(total >>> 34);
        res.status   <= dat_pkg::STATUS_OK;
      end else begin
        res.delay_ns <= '0;
        res.status   <= dat_pkg::STATUS_UNKNOWN;
      end
    end
  end

endmodule

/* rtl/core/detector_arrival_time_delay.sv */
// Arrival-time delay of a plane wave at a detector site, top level.
// Channels: request (item_valid / item_stall / item), result
// (result_valid / result_stall / result), both valid/stall handshakes.
// A request is taken when item_valid is high and item_stall low; a result
// leaves when result_valid is high and result_stall low.
// Throughput: one request per cycle unless result_stall holds a result.
// A request passes the quadrant split, TRIG_STAGES CORDIC stages, the
// quadrant fold and five product/sum/round stages to result_valid.
// The two CORDIC pipelines (right ascension, declination) run side by side.
// Unknown detector codes return status 1 and zero delay.
// Reset clears all valid bits; data registers are not reset.
// While a result waits under result_stall the whole pipeline holds and
// item_stall is raised; nothing is lost or repeated.
// Depends on dat_pkg, dat_trig, dat_cordic_stage and dat_dot.
module detector_arrival_time_delay #(
  parameter int TRIG_STAGES = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  dat_pkg::req_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output dat_pkg::res_t  result
);

  localparam int TRIG_LAT = TRIG_STAGES + 2;
  localparam int LAT      = TRIG_LAT + 5;

  logic en;
  logic [LAT-1:0] vld;
  logic [dat_pkg::DET_BITS-1:0] dets [TRIG_LAT];
  logic [31:0] ra_w, dec_w;
  logic signed [dat_pkg::CW-1:0] cr, sr, cd, sd;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  assign ra_w  = 32'(item.right_ascension) << (32 - dat_pkg::ANGLE_BITS);
  assign dec_w = 32'(item.declination) << (32 - dat_pkg::ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dets[0] <= item.detector;
      for (int i = 1; i < TRIG_LAT; i++) dets[i] <= dets[i-1];
    end
  end

  dat_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_ra (
    .clk(clk), .en(en), .ang(ra_w), .c(cr), .s(sr)
  );

  dat_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig_dec (
    .clk(clk), .en(en), .ang(dec_w), .c(cd), .s(sd)
  );

  dat_dot u_dot (
    .clk(clk), .en(en),
    .cr(cr), .sr(sr), .cd(cd), .sd(sd),
    .det(dets[TRIG_LAT-1]),
    .res(result)
  );

  assign result_valid = vld[LAT-1];

endmodule

/* rtl/core/dat_checker.sv */
// Port-level checks for the arrival-time delay block, bound to the top level.
// Depends on dat_pkg.
module dat_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_valid,
  input logic          item_stall,
  input logic          result_valid,
  input logic          result_stall,
  input dat_pkg::res_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == dat_pkg::STATUS_UNKNOWN |-> result.delay_ns == '0)
    else $error("unknown site with nonzero delay");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("request side stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  logic unused_in;
  assign unused_in = item_valid;

endmodule

bind detector_arrival_time_delay dat_checker u_dat_checker (
  .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
  .result_valid(result_valid), .result_stall(result_stall), .result(result)
);
